@@ src/hdda_pkg.sv @@
package hdda_pkg;

    localparam int unsigned NUM_MONTHS = 12;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 11;

    localparam logic [4:0] HOUR_ROLLOVER  = 5'd0;
    localparam logic [4:0] HOUR_DAY_START = 5'd6;
    localparam logic [4:0] HOUR_MORNING   = 5'd7;
    localparam logic [4:0] HOUR_AFTERNOON = 5'd14;
    localparam logic [4:0] HOUR_EVENING   = 5'd21;
    localparam logic [4:0] HOUR_YEAR_END  = 5'd23;

    localparam logic [4:0] DAY_FIRST = 5'd1;
    localparam logic [4:0] DAY_LAST  = 5'd31;
    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [3:0] MARK_H6  = 4'b0001;
    localparam logic [3:0] MARK_H7  = 4'b0010;
    localparam logic [3:0] MARK_H14 = 4'b0100;
    localparam logic [3:0] MARK_H21 = 4'b1000;

    localparam logic signed [15:0] TEMP_INVALID = 16'sh7FFF;
    localparam logic [4:0]         COUNT_MAX    = 5'd31;
    localparam logic [15:0]        SEL_SUM_MAX  = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_HEATING_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_LOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_HIGH    = 2'd2;

    localparam logic [9:0]         RST_HEATING_LIMIT = 10'd150;
    localparam logic signed [10:0] RST_VALID_LOW     = -11'sd500;
    localparam logic [10:0]        RST_VALID_HIGH    = 11'd600;

    typedef struct packed {
        logic [4:0]         hour;
        logic [4:0]         day;
        logic [3:0]         month;
        logic signed [15:0] outside_temp;
        logic [7:0]         sensor_status;
        logic [3:0]         query_month;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        sel_degree_sum;
        logic [4:0]         sel_heating_days;
        logic [4:0]         sel_rated_days;
        logic [15:0]        sel_prev_degree_sum;
        logic [4:0]         sel_prev_heating_days;
        logic [4:0]         sel_prev_rated_days;
        logic               day_rated;
        logic signed [15:0] daily_mean;
    } t_out_item;

endpackage

@@ src/heating_degree_day_accumulator.sv @@
// Heating degree day accumulator. Takes one item per clock while the result side
// is not stalled (valid/ready on both sides) and returns exactly one result item
// per input item: the input stage reads the twelve-month table (update entry and
// queried entry, registered reads), the second stage applies the hour rules,
// writes the entry back and registers the result. Writes of the item ahead are
// forwarded into the reads of the next one, so back-to-back items stream at one
// per cycle whenever the result side takes them. Table entries have per-month
// valid bits cleared by reset, so the block is usable right after reset with no
// clearing pass. Configuration writes (heating limit, lower and upper reading
// bounds) take effect at once and must only be issued while the block is idle.
module heating_degree_day_accumulator #(
    parameter int unsigned SUM_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hdda_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hdda_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  hdda_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output hdda_pkg::t_out_item             o_out_item
);
    import hdda_pkg::*;

    typedef struct packed {
        logic [SUM_WIDTH-1:0] sum;
        logic [4:0]           heat;
        logic [4:0]           rated;
        logic [SUM_WIDTH-1:0] prev_sum;
        logic [4:0]           prev_heat;
        logic [4:0]           prev_rated;
    } t_entry;

    // config
    logic [9:0]         r_heat_limit;
    logic signed [10:0] r_valid_low;
    logic [10:0]        r_valid_high;

    // state
    logic [3:0]         r_done, n_done;
    logic signed [15:0] r_morning, n_morning;
    logic signed [15:0] r_afternoon, n_afternoon;
    logic [3:0]         r_roll, n_roll;

    // table
    t_entry                r_mem [NUM_MONTHS];
    logic [NUM_MONTHS-1:0] r_vld;

    // stage 1
    logic       r_s1_v;
    t_in_item   r_s1;
    logic [3:0] r_ua;
    logic [3:0] r_qa;
    logic       r_q_ok;
    t_entry     r_rd_u;
    t_entry     r_rd_q;

    // result
    logic      r_out_v;
    t_out_item r_out, n_out;

    logic       s1_fire;
    logic       accept;
    logic       upd_we;
    t_entry     upd_wd;
    t_entry     qe;
    logic [3:0] in_roll;
    logic [3:0] in_ua;
    logic [3:0] in_qa;
    logic       in_q_ok;
    logic       fwd_we;

    logic               reading_ok;
    logic signed [17:0] mean_sum;
    logic signed [17:0] mean18;
    logic signed [17:0] diff18;
    logic [SUM_WIDTH:0] sum_ext;

    function automatic logic in_bounds(input logic signed [15:0] t,
                                       input logic signed [10:0] lo,
                                       input logic [10:0] hi);
        logic signed [16:0] t17;
        logic signed [16:0] lo17;
        logic signed [16:0] hi17;
        t17  = {t[15], t};
        lo17 = {{6{lo[10]}}, lo};
        hi17 = {6'b0, hi};
        return (t17 > lo17) && (t17 < hi17);
    endfunction

    function automatic logic [4:0] count_inc(input logic [4:0] c);
        return (c == COUNT_MAX) ? COUNT_MAX : c + 5'd1;
    endfunction

    function automatic logic [15:0] sat16(input logic [SUM_WIDTH-1:0] v);
        return (v > SUM_WIDTH'(SEL_SUM_MAX)) ? SEL_SUM_MAX : v[15:0];
    endfunction

    assign s1_fire    = r_s1_v && (!r_out_v || i_out_ready);
    assign o_in_ready = !r_s1_v || s1_fire;
    assign accept     = i_in_valid && o_in_ready;
    assign fwd_we     = s1_fire && upd_we;

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heat_limit <= RST_HEATING_LIMIT;
            r_valid_low  <= RST_VALID_LOW;
            r_valid_high <= RST_VALID_HIGH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEATING_LIMIT: r_heat_limit <= i_cfg_wdata[9:0];
                CFG_VALID_LOW:     r_valid_low  <= $signed(i_cfg_wdata);
                CFG_VALID_HIGH:    r_valid_high <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage 1: hour rules
    always_comb begin
        n_done      = r_done;
        n_morning   = r_morning;
        n_afternoon = r_afternoon;
        n_roll      = r_roll;
        upd_we      = 1'b0;
        upd_wd      = r_rd_u;
        reading_ok  = (r_s1.sensor_status == 8'd0) &&
                      in_bounds(r_s1.outside_temp, r_valid_low, r_valid_high);
        mean_sum    = ({{2{r_s1.outside_temp[15]}}, r_s1.outside_temp} <<< 1)
                    + {{2{r_morning[15]}}, r_morning}
                    + {{2{r_afternoon[15]}}, r_afternoon};
        mean18      = (mean_sum + (mean_sum[17] ? 18'sd3 : 18'sd0)) >>> 2;
        diff18      = $signed({8'b0, r_heat_limit}) - mean18;
        sum_ext     = {1'b0, r_rd_u.sum} + {{(SUM_WIDTH - 11){1'b0}}, diff18[11:0]};
        n_out       = '0;

        if (r_s1.month >= MONTH_JAN && r_s1.month <= MONTH_DEC) begin
            case (r_s1.hour)
                HOUR_ROLLOVER: begin
                    if (r_s1.month == MONTH_JAN && r_s1.day == DAY_FIRST &&
                        r_roll < MONTH_DEC) begin
                        upd_we            = 1'b1;
                        upd_wd.prev_sum   = r_rd_u.sum;
                        upd_wd.prev_heat  = r_rd_u.heat;
                        upd_wd.prev_rated = r_rd_u.rated;
                        upd_wd.sum        = '0;
                        upd_wd.heat       = '0;
                        upd_wd.rated      = '0;
                        n_roll            = r_roll + 4'd1;
                    end
                end
                HOUR_DAY_START: begin
                    if ((r_done & MARK_H6) == 4'd0) begin
                        n_morning   = TEMP_INVALID;
                        n_afternoon = TEMP_INVALID;
                        n_done      = MARK_H6;
                        if (r_s1.day == DAY_FIRST && r_s1.month != MONTH_JAN) begin
                            upd_we       = 1'b1;
                            upd_wd.sum   = '0;
                            upd_wd.heat  = '0;
                            upd_wd.rated = '0;
                        end
                    end
                end
                HOUR_MORNING: begin
                    if ((r_done & MARK_H7) == 4'd0 && reading_ok) begin
                        n_morning = r_s1.outside_temp;
                        n_done    = MARK_H7;
                    end
                end
                HOUR_AFTERNOON: begin
                    if ((r_done & MARK_H14) == 4'd0 && reading_ok) begin
                        n_afternoon = r_s1.outside_temp;
                        n_done      = MARK_H14;
                    end
                end
                HOUR_EVENING: begin
                    if ((r_done & MARK_H21) == 4'd0 && reading_ok) begin
                        n_done = MARK_H21;
                        if (in_bounds(r_morning, r_valid_low, r_valid_high) &&
                            in_bounds(r_afternoon, r_valid_low, r_valid_high)) begin
                            upd_we           = 1'b1;
                            n_out.day_rated  = 1'b1;
                            n_out.daily_mean = mean18[15:0];
                            upd_wd.rated     = count_inc(r_rd_u.rated);
                            if (mean18 < $signed({8'b0, r_heat_limit})) begin
                                upd_wd.heat = count_inc(r_rd_u.heat);
                                upd_wd.sum  = sum_ext[SUM_WIDTH] ? '1
                                                                 : sum_ext[SUM_WIDTH-1:0];
                            end
                        end
                    end
                end
                HOUR_YEAR_END: begin
                    if (r_s1.day == DAY_LAST && r_s1.month == MONTH_DEC) begin
                        n_roll = 4'd0;
                    end
                end
                default: ;
            endcase
        end

        qe = (upd_we && r_ua == r_qa) ? upd_wd : r_rd_q;
        if (r_q_ok) begin
            n_out.sel_degree_sum        = sat16(qe.sum);
            n_out.sel_heating_days      = qe.heat;
            n_out.sel_rated_days        = qe.rated;
            n_out.sel_prev_degree_sum   = sat16(qe.prev_sum);
            n_out.sel_prev_heating_days = qe.prev_heat;
            n_out.sel_prev_rated_days   = qe.prev_rated;
        end
    end

    // input side: table addresses for the incoming item
    always_comb begin
        in_roll = s1_fire ? n_roll : r_roll;
        in_q_ok = (i_in_item.query_month >= MONTH_JAN) &&
                  (i_in_item.query_month <= MONTH_DEC);
        in_qa   = in_q_ok ? i_in_item.query_month - 4'd1 : 4'd0;
        if (i_in_item.hour == HOUR_ROLLOVER && i_in_item.month == MONTH_JAN &&
            i_in_item.day == DAY_FIRST) begin
            in_ua = (in_roll < MONTH_DEC) ? in_roll : 4'd0;
        end else if (i_in_item.month >= MONTH_JAN && i_in_item.month <= MONTH_DEC) begin
            in_ua = i_in_item.month - 4'd1;
        end else begin
            in_ua = 4'd0;
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (fwd_we) begin
            r_mem[r_ua] <= upd_wd;
        end
        if (accept) begin
            r_rd_u <= (fwd_we && r_ua == in_ua) ? upd_wd
                    : (r_vld[in_ua] ? r_mem[in_ua] : '0);
            r_rd_q <= (fwd_we && r_ua == in_qa) ? upd_wd
                    : (r_vld[in_qa] ? r_mem[in_qa] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (fwd_we) begin
            r_vld[r_ua] <= 1'b1;
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v      <= 1'b0;
            r_out_v     <= 1'b0;
            r_done      <= 4'd0;
            r_morning   <= TEMP_INVALID;
            r_afternoon <= TEMP_INVALID;
            r_roll      <= 4'd0;
        end else begin
            if (o_in_ready) begin
                r_s1_v <= i_in_valid;
            end
            if (s1_fire) begin
                r_out_v     <= 1'b1;
                r_done      <= n_done;
                r_morning   <= n_morning;
                r_afternoon <= n_afternoon;
                r_roll      <= n_roll;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1   <= i_in_item;
            r_ua   <= in_ua;
            r_qa   <= in_qa;
            r_q_ok <= in_q_ok;
        end
        if (s1_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule

@@ src/hdda_checker.sv @@
module hdda_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [hdda_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [hdda_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input hdda_pkg::t_in_item              i_in_item,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input hdda_pkg::t_out_item             o_out_item
);
    import hdda_pkg::*;

    // no result right after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // empty result stage never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty result stage");

    // heating days never exceed rated days, and no heating day means no sum
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.sel_heating_days <= o_out_item.sel_rated_days) &&
                        (o_out_item.sel_prev_heating_days <=
                         o_out_item.sel_prev_rated_days) &&
                        (o_out_item.sel_heating_days != 5'd0 ||
                         o_out_item.sel_degree_sum == 16'd0))
        else $error("inconsistent month figures");

    // mean is zero unless a day was rated
    a_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.day_rated |-> o_out_item.daily_mean == 16'sd0)
        else $error("mean reported without rated day");

endmodule

bind heating_degree_day_accumulator hdda_checker u_hdda_checker (.*);

@@ dv/tb_heating_degree_day_accumulator.sv @@
module tb_heating_degree_day_accumulator;
    timeunit 1ns;
    timeprecision 1ps;

    import hdda_pkg::*;

    localparam int SUM_WIDTH = 16;
    localparam int SUM_MAX   = (1 << SUM_WIDTH) - 1;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;

    heating_degree_day_accumulator #(
        .SUM_WIDTH(SUM_WIDTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    // mirrored configuration and block state
    int         cfg_limit = RST_HEATING_LIMIT;
    int         cfg_low   = RST_VALID_LOW;
    int         cfg_high  = RST_VALID_HIGH;
    logic [3:0] hours_done = '0;
    int         morning_t   = TEMP_INVALID;
    int         afternoon_t = TEMP_INVALID;
    int         roll_month  = 0;
    int         sum_cur    [NUM_MONTHS];
    int         heat_cur   [NUM_MONTHS];
    int         rated_cur  [NUM_MONTHS];
    int         sum_prev   [NUM_MONTHS];
    int         heat_prev  [NUM_MONTHS];
    int         rated_prev [NUM_MONTHS];

    t_in_item  pending_ticks[$];
    t_out_item predicted_reports[$];
    int        issued_count   = 0;
    int        accepted_count = 0;
    int        error_count    = 0;
    bit        steady         = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit in_bounds(int t);
        return t > cfg_low && t < cfg_high;
    endfunction

    function automatic int count_inc(int c);
        return (c >= COUNT_MAX) ? COUNT_MAX : c + 1;
    endfunction

    function automatic t_out_item predict_tick(t_in_item tick);
        t_out_item res;
        int        temp;
        int        mean;
        int        m;
        int        q;
        bit        usable;
        res    = '0;
        mean   = 0;
        temp   = int'($signed(tick.outside_temp));
        usable = (tick.sensor_status == 8'd0) && in_bounds(temp);
        m      = int'(tick.month) - 1;
        if (tick.month >= MONTH_JAN && tick.month <= MONTH_DEC) begin
            case (tick.hour)
                HOUR_ROLLOVER: begin
                    if (tick.month == MONTH_JAN && tick.day == DAY_FIRST
                            && roll_month < NUM_MONTHS) begin
                        sum_prev[roll_month]   = sum_cur[roll_month];
                        heat_prev[roll_month]  = heat_cur[roll_month];
                        rated_prev[roll_month] = rated_cur[roll_month];
                        sum_cur[roll_month]    = 0;
                        heat_cur[roll_month]   = 0;
                        rated_cur[roll_month]  = 0;
                        roll_month++;
                    end
                end
                HOUR_DAY_START: begin
                    if ((hours_done & MARK_H6) == '0) begin
                        morning_t   = TEMP_INVALID;
                        afternoon_t = TEMP_INVALID;
                        hours_done  = MARK_H6;
                        if (tick.day == DAY_FIRST && tick.month != MONTH_JAN) begin
                            sum_cur[m]   = 0;
                            heat_cur[m]  = 0;
                            rated_cur[m] = 0;
                        end
                    end
                end
                HOUR_MORNING: begin
                    if ((hours_done & MARK_H7) == '0 && usable) begin
                        morning_t  = temp;
                        hours_done = MARK_H7;
                    end
                end
                HOUR_AFTERNOON: begin
                    if ((hours_done & MARK_H14) == '0 && usable) begin
                        afternoon_t = temp;
                        hours_done  = MARK_H14;
                    end
                end
                HOUR_EVENING: begin
                    if ((hours_done & MARK_H21) == '0 && usable) begin
                        if (in_bounds(morning_t) && in_bounds(afternoon_t)) begin
                            mean          = (2 * temp + morning_t + afternoon_t) / 4;
                            res.day_rated = 1'b1;
                            rated_cur[m]  = count_inc(rated_cur[m]);
                            if (mean < cfg_limit) begin
                                heat_cur[m] = count_inc(heat_cur[m]);
                                sum_cur[m]  = sum_cur[m] + (cfg_limit - mean);
                                if (sum_cur[m] > SUM_MAX) begin
                                    sum_cur[m] = SUM_MAX;
                                end
                            end
                        end
                        hours_done = MARK_H21;
                    end
                end
                HOUR_YEAR_END: begin
                    if (tick.day == DAY_LAST && tick.month == MONTH_DEC) begin
                        roll_month = 0;
                    end
                end
                default: ;
            endcase
        end
        q = int'(tick.query_month) - 1;
        if (tick.query_month >= MONTH_JAN && tick.query_month <= MONTH_DEC) begin
            res.sel_degree_sum        = (sum_cur[q] > SEL_SUM_MAX) ? SEL_SUM_MAX
                                                                   : 16'(sum_cur[q]);
            res.sel_heating_days      = 5'(heat_cur[q]);
            res.sel_rated_days        = 5'(rated_cur[q]);
            res.sel_prev_degree_sum   = (sum_prev[q] > SEL_SUM_MAX) ? SEL_SUM_MAX
                                                                    : 16'(sum_prev[q]);
            res.sel_prev_heating_days = 5'(heat_prev[q]);
            res.sel_prev_rated_days   = 5'(rated_prev[q]);
        end
        res.daily_mean = 16'(mean);
        return res;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (accepted_count == issued_count) begin
            if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
                i_in_item <= pending_ticks.pop_front();
                issued_count++;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= steady || $urandom_range(99) >= 6;
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (predicted_reports.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("%0t: result with no item pending", $realtime);
                    end
                end else begin
                    want = predicted_reports.pop_front();
                    if (o_out_item.sel_degree_sum !== want.sel_degree_sum
                            || o_out_item.sel_heating_days !== want.sel_heating_days
                            || o_out_item.sel_rated_days !== want.sel_rated_days
                            || o_out_item.sel_prev_degree_sum !== want.sel_prev_degree_sum
                            || o_out_item.sel_prev_heating_days !== want.sel_prev_heating_days
                            || o_out_item.sel_prev_rated_days !== want.sel_prev_rated_days
                            || o_out_item.day_rated !== want.day_rated
                            || o_out_item.daily_mean !== want.daily_mean) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("%0t: exp sum=%0d heat=%0d rated=%0d prev=%0d/%0d/%0d rd=%0b mean=%0d",
                                     $realtime, want.sel_degree_sum, want.sel_heating_days,
                                     want.sel_rated_days, want.sel_prev_degree_sum,
                                     want.sel_prev_heating_days, want.sel_prev_rated_days,
                                     want.day_rated, want.daily_mean);
                            $display("%0t: got sum=%0d heat=%0d rated=%0d prev=%0d/%0d/%0d rd=%0b mean=%0d",
                                     $realtime, o_out_item.sel_degree_sum,
                                     o_out_item.sel_heating_days, o_out_item.sel_rated_days,
                                     o_out_item.sel_prev_degree_sum,
                                     o_out_item.sel_prev_heating_days,
                                     o_out_item.sel_prev_rated_days,
                                     o_out_item.day_rated, o_out_item.daily_mean);
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                predicted_reports.push_back(predict_tick(i_in_item));
                accepted_count <= accepted_count + 1;
            end
        end
    end

    task automatic push_tick(logic [4:0] hour, logic [4:0] day, logic [3:0] month,
                             logic [15:0] temp, logic [7:0] status, logic [3:0] query);
        t_in_item tick;
        tick.hour          = hour;
        tick.day           = day;
        tick.month         = month;
        tick.outside_temp  = temp;
        tick.sensor_status = status;
        tick.query_month   = query;
        pending_ticks.push_back(tick);
    endtask

    task automatic push_day(logic [4:0] day, logic [3:0] month, logic [15:0] t7,
                            logic [15:0] t14, logic [15:0] t21, logic [3:0] query);
        push_tick(HOUR_DAY_START, day, month, 16'($urandom), 8'($urandom), query);
        push_tick(HOUR_MORNING, day, month, t7, 8'd0, query);
        push_tick(HOUR_AFTERNOON, day, month, t14, 8'd0, query);
        push_tick(HOUR_EVENING, day, month, t21, 8'd0, query);
    endtask

    function automatic logic [15:0] pick_temp();
        if (cfg_high - cfg_low >= 2 && $urandom_range(99) < 85) begin
            return 16'(cfg_low + 1 + int'($urandom_range(cfg_high - cfg_low - 2)));
        end
        return 16'($urandom);
    endfunction

    function automatic logic [3:0] pick_query();
        if ($urandom_range(9) == 0) begin
            return ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
        end
        return 4'($urandom_range(1, NUM_MONTHS));
    endfunction

    task automatic push_random(int n);
        int         added;
        int         r;
        int         burst;
        logic [4:0] d;
        logic [3:0] m;
        logic [4:0] h;
        added = 0;
        while (added < n) begin
            r = $urandom_range(99);
            m = 4'($urandom_range(1, NUM_MONTHS));
            d = ($urandom_range(9) == 0) ? DAY_FIRST : 5'($urandom_range(2, 31));
            if (r < 60) begin
                push_day(d, m, pick_temp(), pick_temp(), pick_temp(), pick_query());
                added += 4;
            end else if (r < 72) begin
                // stray or broken reading within a day
                case ($urandom_range(3))
                    0: h = HOUR_DAY_START;
                    1: h = HOUR_MORNING;
                    2: h = HOUR_AFTERNOON;
                    default: h = HOUR_EVENING;
                endcase
                push_tick(h, d, m, pick_temp(),
                          ($urandom_range(3) == 0) ? 8'($urandom) : 8'd0, pick_query());
                added++;
            end else if (r < 76) begin
                burst = $urandom_range(1, 14);
                repeat (burst) begin
                    push_tick(HOUR_ROLLOVER, DAY_FIRST, MONTH_JAN, 16'($urandom),
                              8'($urandom), pick_query());
                end
                added += burst;
            end else if (r < 80) begin
                push_tick(HOUR_YEAR_END, DAY_LAST, MONTH_DEC, 16'($urandom), 8'($urandom),
                          pick_query());
                added++;
            end else begin
                push_tick(5'($urandom), 5'($urandom), 4'($urandom), 16'($urandom),
                          8'($urandom), 4'($urandom));
                added++;
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_ticks.size() != 0 || accepted_count != issued_count
                || predicted_reports.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_config(int limit, int low, int high);
        write_reg(CFG_HEATING_LIMIT, 11'(limit));
        write_reg(CFG_VALID_LOW, 11'(low));
        write_reg(CFG_VALID_HIGH, 11'(high));
        cfg_limit = limit;
        cfg_low   = low;
        cfg_high  = high;
    endtask

    initial begin
        for (int k = 0; k < NUM_MONTHS; k++) begin
            sum_cur[k]    = 0;
            heat_cur[k]   = 0;
            rated_cur[k]  = 0;
            sum_prev[k]   = 0;
            heat_prev[k]  = 0;
            rated_prev[k] = 0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one January day, bounds, flags, rollover, ignored months, field extremes
        push_tick(5'd3, 5'd5, MONTH_JAN, 16'sd0, 8'd0, 4'd1);
        push_tick(HOUR_DAY_START, DAY_FIRST, MONTH_JAN, 16'sd0, 8'd0, 4'd1);
        push_tick(HOUR_MORNING, DAY_FIRST, MONTH_JAN, 16'sd100, 8'd0, 4'd1);
        push_tick(HOUR_AFTERNOON, DAY_FIRST, MONTH_JAN, 16'sd200, 8'd0, 4'd1);
        push_tick(HOUR_EVENING, DAY_FIRST, MONTH_JAN, 16'sd50, 8'd0, 4'd1);
        push_tick(HOUR_EVENING, DAY_FIRST, MONTH_JAN, 16'sd50, 8'd0, 4'd1);
        push_tick(HOUR_DAY_START, 5'd2, MONTH_JAN, 16'sd0, 8'd0, 4'd1);
        push_tick(HOUR_MORNING, 5'd2, MONTH_JAN, -16'sd500, 8'd0, 4'd1);
        push_tick(HOUR_MORNING, 5'd2, MONTH_JAN, -16'sd499, 8'd0, 4'd1);
        push_tick(HOUR_AFTERNOON, 5'd2, MONTH_JAN, 16'sd599, 8'd3, 4'd1);
        push_tick(HOUR_AFTERNOON, 5'd2, MONTH_JAN, 16'sd600, 8'd0, 4'd1);
        push_tick(HOUR_AFTERNOON, 5'd2, MONTH_JAN, -16'sd498, 8'd0, 4'd1);
        push_tick(HOUR_EVENING, 5'd2, MONTH_JAN, -16'sd1, 8'd0, 4'd1);
        push_tick(HOUR_MORNING, 5'd2, MONTH_JAN, 16'h8000, 8'd0, 4'd1);
        push_tick(HOUR_AFTERNOON, 5'd2, MONTH_JAN, 16'h7FFF, 8'd0, 4'd1);
        push_tick(HOUR_DAY_START, DAY_FIRST, 4'd3, 16'sd0, 8'd0, 4'd3);
        push_tick(HOUR_ROLLOVER, DAY_FIRST, MONTH_JAN, 16'sd0, 8'd0, 4'd1);
        push_tick(HOUR_ROLLOVER, DAY_FIRST, MONTH_JAN, 16'sd0, 8'd0, 4'd2);
        push_tick(HOUR_YEAR_END, DAY_LAST, MONTH_DEC, 16'sd0, 8'd0, 4'd1);
        push_tick(HOUR_ROLLOVER, DAY_FIRST, MONTH_JAN, 16'sd0, 8'd0, 4'd1);
        push_tick(HOUR_EVENING, 5'd5, 4'd0, 16'sd100, 8'd0, 4'd1);
        push_tick(HOUR_DAY_START, 5'd5, 4'd15, 16'sd0, 8'd0, 4'd15);
        push_tick(5'd12, 5'd5, 4'd2, 16'sd0, 8'd0, 4'd0);
        push_tick(5'd31, 5'd31, 4'd15, 16'hFFFF, 8'hFF, 4'd15);
        push_tick(5'd0, 5'd0, 4'd0, 16'h0000, 8'h00, 4'd0);
        wait_idle();

        // cold February: counts and sum saturate, then move to the previous year
        set_config(1000, -1000, 1500);
        steady = 1'b1;
        for (int k = 0; k < 40; k++) begin
            push_day(5'(2 + k % 27), 4'd2, 16'(-999 + int'($urandom_range(9))),
                     16'(-999 + int'($urandom_range(9))),
                     16'(-999 + int'($urandom_range(9))), 4'd2);
        end
        repeat (13) push_tick(HOUR_ROLLOVER, DAY_FIRST, MONTH_JAN, 16'sd0, 8'd0, 4'd2);
        push_tick(HOUR_YEAR_END, DAY_LAST, MONTH_DEC, 16'sd0, 8'd0, 4'd2);
        push_random(100);
        wait_idle();
        steady = 1'b0;

        set_config(0, 0, 0);
        push_random(60);
        wait_idle();

        set_config(0, -1000, 1500);
        push_random(100);
        wait_idle();

        repeat (2) begin
            set_config($urandom_range(1000), -int'($urandom_range(1000)),
                       $urandom_range(1500));
            push_random(150);
            wait_idle();
        end

        set_config(RST_HEATING_LIMIT, RST_VALID_LOW, RST_VALID_HIGH);
        push_random(100);
        wait_idle();

        if (error_count == 0 && predicted_reports.size() == 0) begin
            $display("tb_heating_degree_day_accumulator OK");
        end else begin
            $display("tb_heating_degree_day_accumulator NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_heating_degree_day_accumulator NOT OK");
        $finish;
    end

endmodule
